[sv/wildcard_pattern_search_assert.svh]
// assertion macros for the checker file
`ifndef WILDCARD_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_PATTERN_SEARCH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define WPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wps assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define WPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wps assertion failed");

`endif

[sv/wps_pkg.sv]
// shared constants, types and register codes for the wildcard pattern search
package wps_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int POS_BITS    = 16;
  localparam int REG_BYTES   = 32;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int START_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int OUT_DATA_W  = 24;

  localparam logic [7:0] WILDCARD = 8'h3F;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;

  typedef logic [MAX_PATTERN-1:0][7:0] window_t;
  typedef logic [REG_BYTES-1:0][7:0]   pattern_t;
  typedef logic [LEN_W-1:0]            len_t;
  typedef logic [POS_BITS-1:0]         pos_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
    logic               exact_equal;
    logic               overflow;
  } result_t;

endpackage

[sv/wps_match.sv]
// wildcard compare of the newest window bytes against the pattern
module wps_match (
  input  wps_pkg::window_t  window,
  input  wps_pkg::pattern_t pattern,
  input  wps_pkg::len_t     len,
  output logic              hit
);

  wps_pkg::window_t pat_ext;
  logic [wps_pkg::MAX_PATTERN-1:0] pos_ok;

  // pattern bytes past the register file read as zero
  always_comb begin
    for (int k = 0; k < wps_pkg::MAX_PATTERN; k++) begin
      if (k < wps_pkg::REG_BYTES) begin
        pat_ext[k] = pattern[k];
      end else begin
        pat_ext[k] = 8'h00;
      end
    end
  end

  // window slot j (newest at 0) lines up with pattern byte len-1-j
  always_comb begin
    for (int j = 0; j < wps_pkg::MAX_PATTERN; j++) begin
      wps_pkg::len_t pidx;
      logic [7:0]    pbyte;
      pidx  = wps_pkg::len_t'(len - wps_pkg::len_t'(1) - wps_pkg::len_t'(j));
      pbyte = pat_ext[pidx[wps_pkg::IDX_W-1:0]];
      if (wps_pkg::len_t'(j) < len) begin
        pos_ok[j] = (pbyte == wps_pkg::WILDCARD) || (pbyte == window[j]);
      end else begin
        pos_ok[j] = 1'b1;
      end
    end
  end

  assign hit = &pos_ok;

endmodule

[sv/wps_track.sv]
// per-text state: byte window, position counter and first match tracking
module wps_track (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        text_byte,
  input  logic              last,
  input  wps_pkg::pattern_t pattern,
  input  wps_pkg::len_t     len,
  output wps_pkg::result_t  result
);

  wps_pkg::window_t window_r, window_nxt;
  wps_pkg::pos_t    count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             seen_r, seen_nxt;
  wps_pkg::pos_t    start_r, start_nxt;
  logic             hit;
  logic [31:0]      start_ext;

  always_comb begin
    window_nxt[0] = text_byte;
    for (int i = 1; i < wps_pkg::MAX_PATTERN; i++) begin
      window_nxt[i] = window_r[i-1];
    end
  end

  wps_match u_match (
    .window  (window_nxt),
    .pattern (pattern),
    .len     (len),
    .hit     (hit)
  );

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = seen_r;
    start_nxt = start_r;
    if (&count_r) begin
      // counter saturated: no new match from here on
      ovf_nxt = 1'b1;
    end else begin
      count_nxt = count_r + wps_pkg::pos_t'(1);
      if (!seen_r) begin
        if (len == '0) begin
          seen_nxt  = 1'b1;
          start_nxt = '0;
        end else if (count_nxt >= wps_pkg::pos_t'(len) && hit) begin
          seen_nxt  = 1'b1;
          start_nxt = count_nxt - wps_pkg::pos_t'(len);
        end
      end
    end
  end

  assign start_ext = 32'(start_nxt);

  always_comb begin
    result.found       = seen_nxt;
    result.match_start = seen_nxt ? start_ext[wps_pkg::START_W-1:0] : '0;
    result.exact_equal = (len != '0) && seen_nxt && (start_nxt == '0) &&
                         (count_nxt == wps_pkg::pos_t'(len)) && !ovf_nxt;
    result.overflow    = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      seen_r   <= 1'b0;
      start_r  <= '0;
    end else if (step) begin
      if (last) begin
        window_r <= '0;
        count_r  <= '0;
        ovf_r    <= 1'b0;
        seen_r   <= 1'b0;
        start_r  <= '0;
      end else begin
        window_r <= window_nxt;
        count_r  <= count_nxt;
        ovf_r    <= ovf_nxt;
        seen_r   <= seen_nxt;
        start_r  <= start_nxt;
      end
    end
  end

endmodule

[sv/wildcard_pattern_search.sv]
// Wildcard pattern search top level. Takes one text byte per cycle on the in_ stream,
// registers it, compares the newest bytes against a pattern of up to 32 bytes ('?'
// matches any byte) and puts one result word on the out_ stream for each byte marked
// tlast. Throughput is one byte per cycle unless a last byte stalls; a result word passes
// the input register and then the output register, with the compare logic between them.
// Input keeps flowing while a result waits: only a last byte stalls, and only while the
// previous result is still untaken. cfg_ready is always high; the pattern may be
// rewritten only between texts.
module wildcard_pattern_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] text_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] found, [16:1] match_start, [17] exact_equal, [18] overflow, [23:19] zero
  output logic [wps_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [3:0][63:0]  pat_words_r;
  logic [5:0]        pat_len_r;
  wps_pkg::pattern_t pattern;
  wps_pkg::len_t     len_eff;
  logic [6:0]        len_ext;

  logic              s_valid_r;
  logic [7:0]        s_byte_r;
  logic              s_last_r;
  logic              s_adv;

  logic              o_valid_r;
  wps_pkg::result_t  o_result_r;
  wps_pkg::result_t  result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_words_r <= '0;
      pat_len_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wps_pkg::CFG_PATTERN_WORD_0: pat_words_r[0] <= cfg_data;
        wps_pkg::CFG_PATTERN_WORD_1: pat_words_r[1] <= cfg_data;
        wps_pkg::CFG_PATTERN_WORD_2: pat_words_r[2] <= cfg_data;
        wps_pkg::CFG_PATTERN_WORD_3: pat_words_r[3] <= cfg_data;
        wps_pkg::CFG_PATTERN_LENGTH: pat_len_r      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign pattern = wps_pkg::pattern_t'(pat_words_r);

  // lengths above the window depth act as the full depth
  assign len_ext = 7'(pat_len_r);
  assign len_eff = (len_ext > 7'(wps_pkg::MAX_PATTERN)) ?
                   wps_pkg::len_t'(wps_pkg::MAX_PATTERN) : wps_pkg::len_t'(len_ext);

  // a non-last word never needs the output register
  assign s_adv     = s_valid_r && (!s_last_r || !o_valid_r || out_tready);
  assign in_tready = !s_valid_r || s_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_tready) begin
      s_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_byte_r <= in_tdata;
      s_last_r <= in_tlast;
    end
  end

  wps_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s_adv),
    .text_byte (s_byte_r),
    .last      (s_last_r),
    .pattern   (pattern),
    .len       (len_eff),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s_adv && s_last_r) begin
      o_valid_r <= 1'b1;
    end else if (out_tready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && s_last_r) begin
      o_result_r <= result;
    end
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {5'b0, o_result_r.overflow, o_result_r.exact_equal,
                       o_result_r.match_start, o_result_r.found};

endmodule

[sv/wps_checker.sv]
// port-level checks for the wildcard pattern search, bound to the top level
`include "wildcard_pattern_search_assert.svh"

module wps_port_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [wps_pkg::OUT_DATA_W-1:0] out_tdata
);

  `WPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `WPS_ASSERT_NOW(a_exact_at_zero, out_tvalid && out_tdata[17], out_tdata[0] && out_tdata[16:1] == 16'd0)
  `WPS_ASSERT_NOW(a_miss_clean, out_tvalid && !out_tdata[0], out_tdata[16:1] == 16'd0 && !out_tdata[17])
  `WPS_ASSERT_NOW(a_ovf_not_exact, out_tvalid && out_tdata[18], !out_tdata[17])

endmodule

bind wildcard_pattern_search wps_port_checker u_wps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
